// File: hdl/combination_unrank_core_macros.svh
// Assertion macros shared by the checker of combination_unrank_core.
// Depends on nothing; included by files that hold assertions.
`ifndef COMBINATION_UNRANK_CORE_MACROS_SVH
`define COMBINATION_UNRANK_CORE_MACROS_SVH

// same-cycle implication
`define CU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("combination_unrank_core check failed");

// next-cycle implication
`define CU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("combination_unrank_core check failed");

`endif

// File: hdl/cu_pkg.sv
// Package for combination_unrank_core: widths, register indexes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cu_pkg;
  localparam int RankW   = 61;
  localparam int SizeW   = 7;
  localparam int ProdW   = RankW + SizeW;    // count * picks
  localparam int DigitsPerCycle = 4;
  localparam int DivCycles = (ProdW + DigitsPerCycle - 1) / DigitsPerCycle;
  localparam int DivCntW = $clog2(DivCycles + 1);
  localparam int MaxNDefault = 64;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_SET_SIZE    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SUBSET_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COMBO_TOTAL = 2'd2;

  typedef struct packed {
    logic             start;
    logic [SizeW-1:0] num;   // picks left
    logic [SizeW-1:0] den;   // candidates left
  } scale_req_t;
endpackage
`default_nettype wire

// File: hdl/cu_scale.sv
// Shared scaling unit: floor(count * num / den), one multiply then a
// radix-2 restoring division, four quotient bits per cycle. Uses cu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cu_scale (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cu_pkg::scale_req_t       req,
  input  wire logic [cu_pkg::RankW-1:0] count,
  output logic                          done,
  output logic [cu_pkg::RankW-1:0]      quotient
);
  logic [cu_pkg::ProdW-1:0]   dvd, dvd_next;
  logic [cu_pkg::SizeW-1:0]   rem, rem_next;
  logic [cu_pkg::SizeW-1:0]   den;
  logic [cu_pkg::DivCntW-1:0] steps;
  logic                       busy;

  // four dependent compare/subtract steps on 7-bit values
  always_comb begin
    logic [cu_pkg::SizeW:0]   t;
    logic [cu_pkg::SizeW-1:0] r;
    logic [cu_pkg::ProdW-1:0] d;
    r = rem;
    d = dvd;
    for (int s = 0; s < cu_pkg::DigitsPerCycle; s++) begin
      t = {r, d[cu_pkg::ProdW-1]};
      d = {d[cu_pkg::ProdW-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t    = t - {1'b0, den};
        d[0] = 1'b1;
      end
      r = t[cu_pkg::SizeW-1:0];
    end
    rem_next = r;
    dvd_next = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd   <= count * {{(cu_pkg::ProdW-cu_pkg::SizeW){1'b0}}, req.num};
        den   <= req.den;
        rem   <= '0;
        steps <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        dvd   <= dvd_next;
        rem   <= rem_next;
        steps <= steps + 1'b1;
        if (steps == cu_pkg::DivCntW'(cu_pkg::DivCycles - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd[cu_pkg::RankW-1:0];
endmodule
`default_nettype wire

// File: hdl/combination_unrank_core.sv
// Top level of the lexicographic combination unranker.
// Depends on cu_pkg and cu_scale.
`timescale 1ns / 1ps
`default_nettype none
// Takes a 1-based rank on s_axis and returns the k-subset of {1..n} at that
// rank in lexicographic order on m_axis, one element per transfer, ascending,
// tlast on the final element. A rank of 0 or above combo_total (or a bad
// n/k setting) yields a single transfer with element 0, tlast and tuser set.
// One rank at a time: s_axis_tready is high only while idle. Each candidate
// decision with more than one pick left runs the shared scaling unit (one
// multiply, then division at four bits a cycle) plus control states, and a
// rank examines at most n candidates; each output transfer waits for the
// sink to be ready. Configuration (index 0 set_size, 1 subset_size,
// 2 combo_total) is taken every cycle and must only be written while idle.
module combination_unrank_core #(
  parameter int MAX_N = cu_pkg::MaxNDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [cu_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cu_pkg::RankW-1:0]   cfg_data,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [63:0]                s_axis_tdata,  // [60:0] rank, rest zero
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [6:0] element, [7] zero
  output logic                            m_axis_tlast,  // is_last
  output logic                            m_axis_tuser   // [0] rank_error
);
  typedef enum logic [2:0] {ST_IDLE, ST_START, ST_MUL, ST_DIV, ST_DECIDE, ST_EMIT}
    state_t;

  state_t                   state;
  logic [cu_pkg::SizeW-1:0] set_size, subset_size;
  logic [cu_pkg::RankW-1:0] combo_total;
  logic [cu_pkg::RankW-1:0] xr, cnt;
  logic [cu_pkg::SizeW-1:0] cands, picks;
  logic [cu_pkg::SizeW-1:0] out_elem;
  logic                     out_last, out_err;

  cu_pkg::scale_req_t       req;
  logic                     sc_done;
  logic [cu_pkg::RankW-1:0] ch;
  logic                     bad;

  assign req.start = (state == ST_MUL);
  assign req.num   = picks;
  assign req.den   = cands;

  cu_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .count    (cnt),
    .done     (sc_done),
    .quotient (ch)
  );

  assign bad = (xr == '0) || (xr > combo_total) || (subset_size == '0) ||
               (subset_size > set_size) || (set_size > cu_pkg::SizeW'(MAX_N));

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_EMIT);
  assign m_axis_tdata  = {1'b0, out_elem};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_err;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_size    <= cu_pkg::SizeW'(1);
      subset_size <= cu_pkg::SizeW'(1);
      combo_total <= cu_pkg::RankW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cu_pkg::REG_SET_SIZE:    set_size    <= cfg_data[cu_pkg::SizeW-1:0];
        cu_pkg::REG_SUBSET_SIZE: subset_size <= cfg_data[cu_pkg::SizeW-1:0];
        cu_pkg::REG_COMBO_TOTAL: combo_total <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      xr       <= '0;
      cnt      <= '0;
      cands    <= '0;
      picks    <= '0;
      out_elem <= '0;
      out_last <= 1'b0;
      out_err  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            xr    <= s_axis_tdata[cu_pkg::RankW-1:0];
            state <= ST_START;
          end
        end
        ST_START: begin
          out_err <= bad;
          if (bad) begin
            out_elem <= '0;
            out_last <= 1'b1;
            state    <= ST_EMIT;
          end else begin
            cnt   <= combo_total;
            cands <= set_size;
            picks <= subset_size;
            if (subset_size > cu_pkg::SizeW'(1)) begin
              state <= ST_MUL;
            end else begin
              // single pick: element comes from the rank itself
              out_elem <= xr[cu_pkg::SizeW-1:0];
              out_last <= 1'b1;
              state    <= ST_EMIT;
            end
          end
        end
        ST_MUL: state <= ST_DIV;
        ST_DIV: begin
          if (sc_done) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          cands <= cands - 1'b1;
          if (xr > ch) begin
            xr    <= xr - ch;
            cnt   <= cnt - ch;
            state <= ST_MUL;
          end else begin
            cnt      <= ch;
            picks    <= picks - 1'b1;
            out_elem <= set_size - cands + 1'b1;
            out_last <= 1'b0;
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            if (out_last) begin
              state <= ST_IDLE;
            end else if (picks > cu_pkg::SizeW'(1)) begin
              state <= ST_MUL;
            end else begin
              out_elem <= set_size - cands + xr[cu_pkg::SizeW-1:0];
              out_last <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/cu_checker.sv
// Port-level checks for combination_unrank_core, bound to the top level.
// Depends on cu_pkg and combination_unrank_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "combination_unrank_core_macros.svh"
module cu_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       cfg_valid,
  input wire logic                       cfg_ready,
  input wire logic [cu_pkg::CfgIdxW-1:0] cfg_index,
  input wire logic [cu_pkg::RankW-1:0]   cfg_data,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic [63:0]                s_axis_tdata,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [7:0]                 m_axis_tdata,
  input wire logic                       m_axis_tlast,
  input wire logic                       m_axis_tuser
);
  `CU_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `CU_ASSERT_IMPL(a_err_is_last, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 8'd0))
  `CU_ASSERT_IMPL(a_one_at_a_time, clk, rst, m_axis_tvalid, !s_axis_tready)
  `CU_ASSERT_NEXT(a_busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind combination_unrank_core cu_checker u_cu_checker (.*);
`default_nettype wire
